// ----- hdl/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants for the trial division prime test.
// ----------------------------------------------------------------------------
package tdp_pkg;

	// divisor sequence: 3 first, then 5, 7, 11, 13, ... stepping by 2 and 4
	localparam int FIRST_DIVISOR  = 3;
	localparam int FIRST_SQUARE   = 9;
	localparam int SECOND_DIVISOR = 5;
	localparam int SECOND_SQUARE  = 25;
	localparam int SMALL_STEP     = 2;
	localparam int LARGE_STEP     = 4;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // capture the number
		logic init;       // divisor to its first value
		logic div_start;  // start a remainder
		logic advance;    // move to the next divisor
	} tdp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic lt2;        // number is zero or one
		logic is23;       // number is two or three
		logic even;
		logic sq_gt;      // divisor squared exceeds the number
		logic div_done;   // remainder ready this cycle
		logic rem_zero;
	} tdp_status_t;

endpackage

// ----- hdl/tdp_rem.sv -----
// ----------------------------------------------------------------------------
// tdp_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdp_rem #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic                   rem_zero
);

	localparam int CW = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] sh_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] dvs_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;

	assign trial = {rem_q, sh_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(VALUE_WIDTH - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			sh_q <= {sh_q[VALUE_WIDTH-2:0], 1'b0};
			// partial remainder stays below the divisor, so it fits
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[VALUE_WIDTH-1:0];
			end else begin
				rem_q <= trial[VALUE_WIDTH-1:0];
			end
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule

// ----- hdl/tdp_datapath.sv -----
// ----------------------------------------------------------------------------
// tdp_datapath
// Number, divisor and running divisor square, plus the remainder unit.
// ----------------------------------------------------------------------------
module tdp_datapath
	import tdp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] number,
	input  tdp_cmd_t               cmd,
	output tdp_status_t            status
);

	localparam int SQ_W = VALUE_WIDTH + 2;

	logic [VALUE_WIDTH-1:0] n_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   first_q;
	logic                   large_q;
	logic [SQ_W-1:0]        d_ext;
	logic                   div_done;
	logic                   rem_zero;

	assign d_ext = SQ_W'(d_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= number;
		end
		if (cmd.init) begin
			d_q     <= VALUE_WIDTH'(FIRST_DIVISOR);
			sq_q    <= SQ_W'(FIRST_SQUARE);
			first_q <= 1'b1;
			large_q <= 1'b0;
		end else if (cmd.advance) begin
			if (first_q) begin
				d_q     <= VALUE_WIDTH'(SECOND_DIVISOR);
				sq_q    <= SQ_W'(SECOND_SQUARE);
				first_q <= 1'b0;
				large_q <= 1'b0;
			end else if (large_q) begin
				// (d+4)^2 = d^2 + 8d + 16
				d_q     <= d_q + VALUE_WIDTH'(LARGE_STEP);
				sq_q    <= sq_q + (d_ext << 3) + SQ_W'(LARGE_STEP * LARGE_STEP);
				large_q <= 1'b0;
			end else begin
				// (d+2)^2 = d^2 + 4d + 4
				d_q     <= d_q + VALUE_WIDTH'(SMALL_STEP);
				sq_q    <= sq_q + (d_ext << 2) + SQ_W'(SMALL_STEP * SMALL_STEP);
				large_q <= 1'b1;
			end
		end
	end

	tdp_rem #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.rem_zero (rem_zero)
	);

	always_comb begin
		status.lt2      = (n_q < VALUE_WIDTH'(2));
		status.is23     = (n_q == VALUE_WIDTH'(2)) || (n_q == VALUE_WIDTH'(3));
		status.even     = ~n_q[0];
		status.sq_gt    = (sq_q > SQ_W'(n_q));
		status.div_done = div_done;
		status.rem_zero = rem_zero;
	end

endmodule

// ----- hdl/tdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdp_ctrl
// Sequencer for the test and the stream handshakes, with the result register.
// ----------------------------------------------------------------------------
module tdp_ctrl
	import tdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        result,
	output tdp_cmd_t    cmd,
	input  tdp_status_t status
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_TEST  = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_q;
	logic       res_d;
	logic       res_set;
	logic       out_valid_q;
	logic       out_q;
	logic       out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		res_set = 1'b0;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (status.lt2) begin
					res_set = 1'b1;
					res_d   = 1'b0;
				end else if (status.is23) begin
					res_set = 1'b1;
					res_d   = 1'b1;
				end else if (status.even) begin
					res_set = 1'b1;
					res_d   = 1'b0;
				end else begin
					cmd.init = 1'b1;
					state_d  = ST_TEST;
				end
				if (res_set) begin
					state_d = ST_DONE;
				end
			end
			ST_TEST: begin
				if (status.sq_gt) begin
					res_d   = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.div_done) begin
					if (status.rem_zero) begin
						res_d   = 1'b0;
						state_d = ST_DONE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = ST_TEST;
					end
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign result   = out_q;

endmodule

// ----- hdl/trial_division_prime_test.sv -----
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Stream block that reports whether an unsigned number is prime.
// ----------------------------------------------------------------------------
// One number is tested at a time. Zero, one, two, three and even numbers are
// settled before any division. Other numbers are tried against 3, then 5, 7,
// 11, 13, ... while the divisor squared does not exceed the number; each
// divisor is tested by the one-bit-per-cycle remainder unit. The divisor
// square is kept as a running sum, so no multiplier is used. A finished result
// waits in an output register while the next number is taken.
module trial_division_prime_test
	import tdp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // number
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata   // is_prime, zero fill
);

	tdp_cmd_t    cmd;
	tdp_status_t status;
	logic        result;

	tdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.result   (result),
		.cmd      (cmd),
		.status   (status)
	);

	tdp_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.number (s_tdata[VALUE_WIDTH-1:0]),
		.cmd    (cmd),
		.status (status)
	);

	assign m_tdata = {7'b0, result};

endmodule

// ----- hdl/tdp_checker.sv -----
// ----------------------------------------------------------------------------
// tdp_checker
// Port-level checks for the trial division prime test.
// ----------------------------------------------------------------------------
module tdp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// fill bits above the flag stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:1] == 7'b0))
		else $error("result fill bits not zero");

	// one number at a time: busy right after an accepted item
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready high right after accept");

	// a new result appears only as the block goes back to taking input
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result appeared while busy");

	// accepting a number never makes a result valid at once
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result too early");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks trial_division_prime_test against its own primality predictor.
// ----------------------------------------------------------------------------
// Numbers go in on the slave stream and one verdict per number comes back on
// the master stream. Each accepted number is predicted here by trial division
// and the verdict byte is checked in order. Directed cases cover zero, one,
// two, three, multiples of two and three, prime squares and wide values.
// Random numbers are mostly below 2^16 so the run stays short. Wide random
// numbers always carry a small factor, so the divisor loop ends early.
// Backpressure and drain pauses exercise the full input and output registers.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] number;
		logic [7:0]  verdict;
	} prime_case_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // number
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // is_prime, zero fill

	prime_case_t pending_verdicts[$];
	int          error_count = 0;
	bit          sender_gaps = 1'b1;
	bit          receiver_gaps = 1'b1;
	int          hold_request = 0;

	trial_division_prime_test #(
		.VALUE_WIDTH(32)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit prime_by_trial(input logic [31:0] value);
		longint unsigned n;
		longint unsigned divisor;
		longint unsigned stride;
		n       = value;
		divisor = 5;
		stride  = 2;
		if (n < 2) return 1'b0;
		if (n == 2 || n == 3) return 1'b1;
		if (n % 2 == 0 || n % 3 == 0) return 1'b0;
		while (divisor * divisor <= n) begin
			if (n % divisor == 0) return 1'b0;
			divisor = divisor + stride;
			stride  = 6 - stride;
		end
		return 1'b1;
	endfunction

	task automatic send_number(input logic [31:0] value);
		prime_case_t entry;
		while (sender_gaps && $urandom_range(99) < 26) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		entry.number  = value;
		entry.verdict = {7'b0, prime_by_trial(value)};
		pending_verdicts.push_back(entry);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
	endtask

	// wide random number with a small odd factor, so the loop stops early
	function automatic logic [31:0] wide_composite();
		logic [31:0] value;
		int unsigned factor;
		value  = $urandom;
		factor = 5 + 2 * $urandom_range(0, 20);
		return value - value % factor;
	endfunction

	task automatic test_special_values();
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'd2);
		send_number(32'd3);
		send_number(32'd4);
		send_number(32'd6);
		send_number(32'd9);
		send_number(32'hFFFF_FFFE);
		send_number(32'hFFFF_FFFF);
	endtask

	// primes, prime squares and products that land on both stride values
	task automatic test_divisor_boundaries();
		send_number(32'd5);
		send_number(32'd7);
		send_number(32'd25);
		send_number(32'd35);
		send_number(32'd49);
		send_number(32'd121);
		send_number(32'd143);
		send_number(32'd169);
	endtask

	task automatic test_wide_values();
		send_number(32'h8000_0000);
		send_number(32'hFFFF_FFF5);
		send_number(32'd16777213);
		send_number(32'd1052651);
	endtask

	// receiver holds off while the sender keeps offering quick items
	task automatic test_backpressure();
		sender_gaps  = 1'b0;
		hold_request = 400;
		repeat (6) send_number($urandom_range(0, 255) & 32'hFFFF_FFFE);
		repeat (4) send_number($urandom_range(0, 63));
		sender_gaps = 1'b1;
	endtask

	task automatic test_drain_pause();
		send_number($urandom_range(0, 65535));
		send_number($urandom_range(0, 65535));
		wait_for_drain();
		send_number($urandom_range(0, 255));
	endtask

	task automatic test_random_mix(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			sender_gaps   = (i >= 30);
			receiver_gaps = (i >= 30);
			pick = $urandom_range(99);
			if (pick < 20)
				send_number($urandom_range(0, 255));
			else if (pick < 65)
				send_number($urandom_range(0, 65535));
			else
				send_number(wide_composite());
		end
	endtask

	always @(posedge clk) begin : verdict_check
		prime_case_t want;
		int hold_left;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: verdict %h with no number pending", $time, m_tdata);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (m_tdata !== want.verdict) begin
					$display("%0t: number %0d expected %h actual %h",
						$time, want.number, want.verdict, m_tdata);
					error_count++;
				end
			end
		end
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !receiver_gaps || $urandom_range(99) >= 26;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_divisor_boundaries();
		test_wide_values();
		test_backpressure();
		test_drain_pause();
		test_random_mix(66);
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("%0t: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
